[rtl/core/cft_pkg.sv]
package cft_pkg;

   // Field widths of the byte stream and of the register port.
   localparam int ByteWidth = 8;
   localparam int ModeWidth = 3;
   localparam int CsrIndexWidth = 2;

   // Register indexes on the configuration port.
   localparam logic [CsrIndexWidth-1:0] CSR_DELIMITER = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_QUOTE_CHAR = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_LINE_END = 2'd2;

   // Reset values: comma, double quote, line feed.
   localparam logic [ByteWidth-1:0] DELIMITER_RESET = 8'd44;
   localparam logic [ByteWidth-1:0] QUOTE_CHAR_RESET = 8'd34;
   localparam logic [ByteWidth-1:0] LINE_END_RESET = 8'd10;

   // Parser modes.
   localparam logic [ModeWidth-1:0] MODE_REC_START = 3'd0;
   localparam logic [ModeWidth-1:0] MODE_FIELD_START = 3'd1;
   localparam logic [ModeWidth-1:0] MODE_UNQUOTED = 3'd2;
   localparam logic [ModeWidth-1:0] MODE_QUOTED = 3'd3;
   localparam logic [ModeWidth-1:0] MODE_QUOTE_SEEN = 3'd4;
   localparam logic [ModeWidth-1:0] MODE_AFTER_CLOSE = 3'd5;

   // Current register settings.
   typedef struct packed {
      logic [ByteWidth-1:0] delimiter;
      logic [ByteWidth-1:0] quote_char;
      logic [ByteWidth-1:0] line_end;
   } cfg_type;

   // One result item.
   typedef struct packed {
      logic [ByteWidth-1:0] out_byte;
      logic                 byte_valid;
      logic                 field_end;
      logic                 record_end;
      logic                 record_aborted;
   } result_type;

endpackage

[rtl/core/cft_csr.sv]
module cft_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [cft_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [cft_pkg::ByteWidth-1:0]     csr_data,
   output cft_pkg::cfg_type                 cfg
);
   import cft_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes are always taken; an index beyond the list changes nothing.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_DELIMITER:  cfg_in.delimiter = csr_data;
            CSR_QUOTE_CHAR: cfg_in.quote_char = csr_data;
            CSR_LINE_END:   cfg_in.line_end = csr_data;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delimiter <= DELIMITER_RESET;
         cfg_ff.quote_char <= QUOTE_CHAR_RESET;
         cfg_ff.line_end <= LINE_END_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/core/cft_decode.sv]
module cft_decode (
   input  logic [cft_pkg::ModeWidth-1:0] mode,
   input  logic [cft_pkg::ByteWidth-1:0] in_byte,
   input  logic                          end_of_data,
   input  cft_pkg::cfg_type              cfg,
   output logic [cft_pkg::ModeWidth-1:0] mode_next,
   output cft_pkg::result_type           result
);
   import cft_pkg::*;

   logic [ModeWidth-1:0] mode_eff;
   logic                 is_quote;
   logic                 is_line_end;
   logic                 is_delim;

   // Codes that the parser never enters behave as record start.
   assign mode_eff = (mode > MODE_AFTER_CLOSE) ? MODE_REC_START : mode;
   assign is_quote = (in_byte == cfg.quote_char);
   assign is_line_end = (in_byte == cfg.line_end);
   assign is_delim = (in_byte == cfg.delimiter);

   // One decision per byte. Inside quotes, and after a quote seen there, the
   // quote test wins; elsewhere, line end beats delimiter, which beats quote.
   always_comb begin
      mode_next = mode_eff;
      result = '0;
      if (end_of_data) begin
         mode_next = MODE_REC_START;
         if (mode_eff == MODE_QUOTED) begin
            result.record_end = 1'b1;
            result.record_aborted = 1'b1;
         end else if (mode_eff != MODE_REC_START) begin
            result.field_end = 1'b1;
            result.record_end = 1'b1;
         end
      end else if (mode_eff == MODE_QUOTED) begin
         if (is_quote) begin
            mode_next = MODE_QUOTE_SEEN;
         end else begin
            result.out_byte = in_byte;
            result.byte_valid = 1'b1;
         end
      end else if (mode_eff == MODE_QUOTE_SEEN && is_quote) begin
         // A doubled quote stands for one literal quote.
         mode_next = MODE_QUOTED;
         result.out_byte = in_byte;
         result.byte_valid = 1'b1;
      end else if (is_line_end) begin
         mode_next = MODE_REC_START;
         if (mode_eff != MODE_REC_START) begin
            result.field_end = 1'b1;
            result.record_end = 1'b1;
         end
      end else if (is_delim) begin
         mode_next = MODE_FIELD_START;
         result.field_end = 1'b1;
      end else begin
         case (mode_eff)
            MODE_REC_START, MODE_FIELD_START: begin
               if (is_quote) begin
                  mode_next = MODE_QUOTED;
               end else begin
                  mode_next = MODE_UNQUOTED;
                  result.out_byte = in_byte;
                  result.byte_valid = 1'b1;
               end
            end
            MODE_UNQUOTED: begin
               result.out_byte = in_byte;
               result.byte_valid = 1'b1;
            end
            default: begin
               // Stray bytes after a closing quote are dropped.
               mode_next = MODE_AFTER_CLOSE;
            end
         endcase
      end
   end

endmodule

[rtl/core/csv_field_tokenizer.sv]
// CSV field tokenizer: takes one text byte per request and gives one result
// per request, in order. A result carries a content byte (tuser bit 0) and
// may flag a field end (tuser bit 1), a record end (tlast) or a record
// dropped because the data ended inside open quotes (tuser bit 2). A request
// with tlast set marks the end of the data; its byte is ignored. The block
// accepts one request every clock cycle unless the result stream stalls and
// returns its result through the input and result registers; the single mode
// register, updated once per byte, sets that rate. Delimiter, quote and
// line-end bytes are programmable through the csr port and default to comma,
// double quote and line feed; write them only while no request is in flight.
module csv_field_tokenizer (
   input  logic                             clock,
   input  logic                             reset,
   // Request stream.
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,  // in_byte
   input  logic                             req_tlast,  // end_of_data
   // Result stream.
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [7:0]                       rsp_tdata,  // out_byte
   output logic [2:0]                       rsp_tuser,  // byte_valid, field_end,
                                                        // record_aborted
   output logic                             rsp_tlast,  // record_end
   // Configuration writes.
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [cft_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [7:0]                       csr_data
);
   import cft_pkg::*;

   cfg_type              cfg;
   logic                 in_vld_ff;
   logic                 in_vld_in;
   logic [ByteWidth-1:0] in_byte_ff;
   logic                 in_eod_ff;
   logic [ModeWidth-1:0] mode_ff;
   logic [ModeWidth-1:0] mode_in;
   logic                 out_vld_ff;
   logic                 out_vld_in;
   result_type           out_ff;
   result_type           result;
   logic                 advance;
   logic                 take_req;

   cft_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   cft_decode u_decode (
      .mode        (mode_ff),
      .in_byte     (in_byte_ff),
      .end_of_data (in_eod_ff),
      .cfg         (cfg),
      .mode_next   (mode_in),
      .result      (result)
   );

   // The held request moves to the result register when that is free or
   // being emptied; a new request enters whenever the input stage frees up.
   assign advance = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;
   assign take_req = req_tvalid && req_tready;
   assign in_vld_in = take_req || (in_vld_ff && !advance);
   assign out_vld_in = advance || (out_vld_ff && !rsp_tready);

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
         mode_ff <= MODE_REC_START;
      end else begin
         in_vld_ff <= in_vld_in;
         out_vld_ff <= out_vld_in;
         if (advance) begin
            mode_ff <= mode_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (take_req) begin
         in_byte_ff <= req_tdata;
         in_eod_ff <= req_tlast;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata = out_ff.out_byte;
   assign rsp_tuser = {out_ff.record_aborted, out_ff.field_end, out_ff.byte_valid};
   assign rsp_tlast = out_ff.record_end;

`ifndef ASSERT_OFF
   // An aborted record closes the record but never a field, and has no byte.
   a_abort_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[2]) |-> (rsp_tlast && !rsp_tuser[1] && !rsp_tuser[0]))
      else $error("aborted record result has wrong flags");

   // A content byte never comes with a field or record end.
   a_byte_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (!rsp_tuser[1] && !rsp_tlast))
      else $error("content byte flagged together with an end");

   // End of data always returns the parser to record start.
   a_eod_resets_mode: assert property (@(posedge clock) disable iff (reset)
      (advance && in_eod_ff) |=> (mode_ff == MODE_REC_START))
      else $error("mode not at record start after end of data");

   // A field end inside a record leaves a new empty field open.
   a_delim_mode: assert property (@(posedge clock) disable iff (reset)
      (advance && result.field_end && !result.record_end)
      |=> (mode_ff == MODE_FIELD_START))
      else $error("mode not at field start after delimiter");
`endif

endmodule

[tb/sv/tb_csv_field_tokenizer.sv]
`timescale 1ns / 100ps

module tb_csv_field_tokenizer;
   import cft_pkg::*;

   // Register index with no register behind it; writes to it must be ignored.
   localparam logic [CsrIndexWidth-1:0] CSR_UNMAPPED = 2'd3;
   localparam int StallLimit = 2000;
   localparam int DrainCycles = 10;

   typedef struct packed {
      logic [ByteWidth-1:0] in_byte;
      logic                 eod;
   } text_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [7:0]               req_tdata = 8'h00;
   logic                     req_tlast = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [7:0]               rsp_tdata;
   logic [2:0]               rsp_tuser;
   logic                     rsp_tlast;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index = CSR_DELIMITER;
   logic [7:0]               csr_data = 8'h00;

   // Bytes waiting to be sent and the predicted results still owed by the block.
   text_item_type text_queue[$];
   result_type token_queue[$];

   // Predictor state: mirrored registers and the current parse mode.
   cfg_type              tok_cfg;
   logic [ModeWidth-1:0] tok_mode;

   int pushed_items = 0;
   int mismatch_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int idle_cycles = 0;

   result_type want;
   result_type got;
   result_type predicted;

   csv_field_tokenizer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   // Works out the result of one byte and advances the parse mode.
   function automatic result_type tokenize_byte(input logic [7:0] c, input logic eod);
      result_type r;
      logic [ModeWidth-1:0] m;
      r = '0;
      m = tok_mode;
      if (m > MODE_AFTER_CLOSE) m = MODE_REC_START;
      if (eod) begin
         tok_mode = MODE_REC_START;
         if (m == MODE_QUOTED) begin
            r.record_end = 1'b1;
            r.record_aborted = 1'b1;
         end else if (m != MODE_REC_START) begin
            r.field_end = 1'b1;
            r.record_end = 1'b1;
         end
      end else if (m == MODE_QUOTED) begin
         // Inside quotes everything but the quote byte is content.
         if (c == tok_cfg.quote_char) begin
            tok_mode = MODE_QUOTE_SEEN;
         end else begin
            r.out_byte = c;
            r.byte_valid = 1'b1;
         end
      end else if (m == MODE_QUOTE_SEEN && c == tok_cfg.quote_char) begin
         // A doubled quote stands for one literal quote.
         tok_mode = MODE_QUOTED;
         r.out_byte = c;
         r.byte_valid = 1'b1;
      end else if (c == tok_cfg.line_end) begin
         tok_mode = MODE_REC_START;
         if (m != MODE_REC_START) begin
            r.field_end = 1'b1;
            r.record_end = 1'b1;
         end
      end else if (c == tok_cfg.delimiter) begin
         tok_mode = MODE_FIELD_START;
         r.field_end = 1'b1;
      end else begin
         case (m)
            MODE_REC_START, MODE_FIELD_START: begin
               if (c == tok_cfg.quote_char) begin
                  tok_mode = MODE_QUOTED;
               end else begin
                  tok_mode = MODE_UNQUOTED;
                  r.out_byte = c;
                  r.byte_valid = 1'b1;
               end
            end
            MODE_UNQUOTED: begin
               r.out_byte = c;
               r.byte_valid = 1'b1;
            end
            default: begin
               // Anything after the closing quote is dropped.
               tok_mode = MODE_AFTER_CLOSE;
            end
         endcase
      end
      return r;
   endfunction

   // Request driver: predicts each accepted byte and offers the next one.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predicted = tokenize_byte(req_tdata, req_tlast);
            token_queue.insert(token_queue.size(), predicted);
         end
         if (!req_tvalid || req_tready) begin
            if (text_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata <= text_queue[0].in_byte;
               req_tlast <= text_queue[0].eod;
               void'(text_queue.pop_front());
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   task automatic report_field(input string name, input logic [7:0] exp_val,
                               input logic [7:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val,
                  act_val);
         mismatch_count++;
      end
   endtask

   // Result monitor: compares every accepted result with the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tdata, rsp_tuser[0], rsp_tuser[1], rsp_tlast, rsp_tuser[2]};
            if (token_queue.size() == 0) begin
               $display("%0t: result with none expected, expected none, actual %0h",
                        $time, got);
               mismatch_count++;
            end else begin
               want = token_queue.pop_front();
               report_field("out_byte", want.out_byte, got.out_byte);
               report_field("byte_valid", 8'(want.byte_valid), 8'(got.byte_valid));
               report_field("field_end", 8'(want.field_end), 8'(got.field_end));
               report_field("record_end", 8'(want.record_end), 8'(got.record_end));
               report_field("record_aborted", 8'(want.record_aborted),
                            8'(got.record_aborted));
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog: ends the run when no handshake of any kind happens for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles >= StallLimit) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   task automatic write_csr(input logic [CsrIndexWidth-1:0] idx, input logic [7:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_DELIMITER:  tok_cfg.delimiter = val;
         CSR_QUOTE_CHAR: tok_cfg.quote_char = val;
         CSR_LINE_END:   tok_cfg.line_end = val;
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (text_queue.size() != 0 || req_tvalid || token_queue.size() != 0);
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   task automatic add_byte(input logic [7:0] b);
      text_item_type item;
      item = '{b, 1'b0};
      text_queue.insert(text_queue.size(), item);
      pushed_items++;
   endtask

   // The byte is ignored at end of data, so it is random to exercise its bits.
   task automatic add_end_of_data();
      text_item_type item;
      item = '{8'($urandom_range(255)), 1'b1};
      text_queue.insert(text_queue.size(), item);
      pushed_items++;
   endtask

   task automatic add_string(input string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endtask

   // Random byte that hits the three special bytes often.
   function automatic logic [7:0] any_byte();
      case ($urandom_range(5))
         0: return tok_cfg.delimiter;
         1: return tok_cfg.quote_char;
         2: return tok_cfg.line_end;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // One field, quoted or not, with random content; quoted ones may carry stray bytes.
   task automatic add_field();
      int len;
      logic [7:0] b;
      len = ($urandom_range(15) == 0) ? $urandom_range(7, 16) : $urandom_range(0, 5);
      if ($urandom_range(2) == 0) begin
         add_byte(tok_cfg.quote_char);
         for (int i = 0; i < len; i++) begin
            b = ($urandom_range(3) == 0) ? any_byte() : 8'($urandom_range(255));
            add_byte(b);
            if (b == tok_cfg.quote_char) add_byte(b);
         end
         add_byte(tok_cfg.quote_char);
         // Occasional stray bytes after the closing quote.
         if ($urandom_range(5) == 0) begin
            repeat ($urandom_range(1, 3)) begin
               do b = 8'($urandom_range(255));
               while (b == tok_cfg.quote_char || b == tok_cfg.delimiter ||
                      b == tok_cfg.line_end);
               add_byte(b);
            end
         end
      end else begin
         for (int i = 0; i < len; i++) begin
            do b = 8'($urandom_range(255));
            while (b == tok_cfg.delimiter || b == tok_cfg.line_end ||
                   (i == 0 && b == tok_cfg.quote_char));
            add_byte(b);
         end
      end
   endtask

   task automatic add_record();
      int fields;
      fields = $urandom_range(1, 5);
      for (int f = 0; f < fields; f++) begin
         if (f != 0) add_byte(tok_cfg.delimiter);
         add_field();
      end
      if ($urandom_range(9) == 0) add_end_of_data();
      else add_byte(tok_cfg.line_end);
   endtask

   // Mostly well-formed records; the rest is noise and broken quoting.
   task automatic add_random_text(input int count);
      int target;
      int sel;
      target = pushed_items + count;
      while (pushed_items < target) begin
         sel = $urandom_range(19);
         if (sel < 14) begin
            add_record();
         end else if (sel < 16) begin
            repeat ($urandom_range(1, 6)) add_byte(any_byte());
         end else if (sel < 18) begin
            add_byte(tok_cfg.quote_char);
            repeat ($urandom_range(0, 4)) add_byte(any_byte());
            add_end_of_data();
         end else if (sel == 18) begin
            add_byte(tok_cfg.line_end);
         end else begin
            add_end_of_data();
         end
      end
   endtask

   initial begin
      tok_cfg = '{DELIMITER_RESET, QUOTE_CHAR_RESET, LINE_END_RESET};
      tok_mode = MODE_REC_START;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Default settings: trailing delimiter, doubled quote, empty line,
      // stray bytes after a closing quote, byte extremes, a quote inside an
      // unquoted field, and end of data in quotes, in a field and at record start.
      set_idling(38, 65);
      add_string("a,\"b\"\"c\",\n");
      add_string("\n");
      add_string("\"x\"y\n");
      add_byte(8'h00);
      add_byte(8'hFF);
      add_string("\"q");
      add_end_of_data();
      add_string("z,y\"");
      add_end_of_data();
      add_end_of_data();
      add_random_text(200);

      // The sender holds off until every result is back.
      wait_drained();
      repeat ($urandom_range(1, 20)) @(posedge clock);
      add_random_text(200);
      wait_drained();

      // Extreme register values, plus a write to an unmapped index.
      write_csr(CSR_DELIMITER, 8'h00);
      write_csr(CSR_QUOTE_CHAR, 8'hFF);
      write_csr(CSR_LINE_END, 8'h0D);
      write_csr(CSR_UNMAPPED, 8'($urandom_range(255)));
      set_idling(65, 38);
      add_random_text(350);
      wait_drained();

      // All three special bytes equal: line end takes precedence.
      write_csr(CSR_DELIMITER, 8'h7C);
      write_csr(CSR_QUOTE_CHAR, 8'h7C);
      write_csr(CSR_LINE_END, 8'h7C);
      set_idling(0, 0);
      add_random_text(100);
      wait_drained();

      // Random settings.
      write_csr(CSR_DELIMITER, 8'($urandom_range(255)));
      write_csr(CSR_QUOTE_CHAR, 8'($urandom_range(255)));
      write_csr(CSR_LINE_END, 8'($urandom_range(255)));
      add_random_text(275);
      wait_drained();

      repeat (DrainCycles) @(posedge clock);
      if (token_queue.size() != 0) begin
         $display("%0t: results missing, expected %0d more, actual 0", $time,
                  token_queue.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

[files.f]
rtl/core/cft_pkg.sv
rtl/core/cft_csr.sv
rtl/core/cft_decode.sv
rtl/core/csv_field_tokenizer.sv
tb/sv/tb_csv_field_tokenizer.sv
